### src/cal_pkg.sv
`timescale 1ns / 1ps

package cal_pkg;

	// Command codes
	localparam logic [2:0] CMD_GET    = 3'd0;
	localparam logic [2:0] CMD_SET    = 3'd1;
	localparam logic [2:0] CMD_APPEND = 3'd2;
	localparam logic [2:0] CMD_DROP   = 3'd3;
	localparam logic [2:0] CMD_INSERT = 3'd4;
	localparam logic [2:0] CMD_REMOVE = 3'd5;
	localparam logic [2:0] CMD_PUSH   = 3'd6;
	localparam logic [2:0] CMD_POP    = 3'd7;

	// Status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_BAD_INDEX = 2'd1;
	localparam logic [1:0] ST_FULL      = 2'd2;
	localparam logic [1:0] ST_EMPTY     = 2'd3;

	// Fixed field widths
	localparam int CMD_W   = 3;
	localparam int POS_W   = 10;
	localparam int WORD_W  = 32;
	localparam int CAP_W   = 11;
	localparam int STAT_W  = 2;
	localparam int CNT_O_W = 11;
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	// Register map
	localparam logic [PADDR_W-1:0] REG_CAPACITY = 3'd0;
	localparam logic [CAP_W-1:0]   CAP_RESET    = 11'd1024;

	typedef logic [CAP_W-1:0] cap_t;

endpackage

### src/cal_apb.sv
`timescale 1ns / 1ps

module cal_apb (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [cal_pkg::PADDR_W-1:0]   paddr,
	input  logic [cal_pkg::PDATA_W-1:0]   pwdata,
	output logic [cal_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready,
	output cal_pkg::cap_t                 capacity
);

	cal_pkg::cap_t capacity_q;
	logic          wr_en;
	logic          sel_cap;

	// Only word 0 is mapped; byte lanes within it all hit the capacity register
	assign sel_cap = (paddr[cal_pkg::PADDR_W-1] == cal_pkg::REG_CAPACITY[cal_pkg::PADDR_W-1]);
	assign wr_en   = psel && penable && pwrite && sel_cap;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= cal_pkg::CAP_RESET;
		end else if (wr_en) begin
			capacity_q <= pwdata[cal_pkg::CAP_W-1:0];
		end
	end

	// Read mux
	assign prdata   = sel_cap ? cal_pkg::PDATA_W'(capacity_q) : '0;
	assign capacity = capacity_q;

endmodule

### src/contiguous_array_list_top.sv
`timescale 1ns / 1ps

// Contiguous array list: an ordered list of words packed at the front of a
// single-port-read / single-port-write store, with an entry count.
// Command channel: a transaction is taken on a rising edge with start high
// and busy low (cmd, position, word_in). Exactly one result follows, shown
// for one cycle with done high (read_word, status, entry_count); the
// receiver has no way to stall it and must take it in that cycle.
// Path from the accepting edge to done:
//   set, append, drop last, errors, push front on empty list: the next cycle
//   get: through S_GET (registered store read)
//   insert at k / push front: shift loop in S_SHUP, then S_FIN
//   remove at k / pop front: shift loop in S_SHDN, then S_FIN (done directly if k is the last entry)
// The shift loop moves one entry per cycle through the store's read and
// write ports. busy stays high until the done cycle; a new command may be
// accepted in the done cycle. capacity is to be written over the APB port
// only while idle; the block itself does not enforce this. Values above
// DEPTH act as DEPTH. Reset clears the count and sets capacity to 1024; store
// contents are left as they are and only entries below the count are read.
module contiguous_array_list_top #(
	parameter int DEPTH     = 1024,
	parameter int WORD_BITS = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// command channel
	input  logic                          start,
	output logic                          busy,
	input  logic [cal_pkg::CMD_W-1:0]     cmd,
	input  logic [cal_pkg::POS_W-1:0]     position,
	input  logic signed [cal_pkg::WORD_W-1:0] word_in,
	// result channel
	output logic                          done,
	output logic signed [cal_pkg::WORD_W-1:0] read_word,
	output logic [cal_pkg::STAT_W-1:0]    status,
	output logic [cal_pkg::CNT_O_W-1:0]   entry_count,
	// configuration port
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [cal_pkg::PADDR_W-1:0]   paddr,
	input  logic [cal_pkg::PDATA_W-1:0]   pwdata,
	output logic [cal_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready
);

	localparam int AW    = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int CMP_W = (CNT_W > cal_pkg::CAP_W) ? CNT_W : cal_pkg::CAP_W;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_GET  = 3'd1;
	localparam logic [2:0] S_SHUP = 3'd2;
	localparam logic [2:0] S_SHDN = 3'd3;
	localparam logic [2:0] S_FIN  = 3'd4;

	cal_pkg::cap_t capacity;

	logic [2:0]                    state_q;
	logic [AW-1:0]                 ptr_q;
	logic [AW-1:0]                 pos_q;
	logic [WORD_BITS-1:0]          word_q;
	logic                          ins_q;
	logic [CNT_W-1:0]              count_q;
	logic                          done_q;
	logic [cal_pkg::WORD_W-1:0]    rword_q;
	logic [cal_pkg::STAT_W-1:0]    status_q;
	logic [WORD_BITS-1:0]          rdata_q;

	logic [WORD_BITS-1:0]          mem [DEPTH];

	logic                          accept;
	logic                          full;
	logic                          valid;
	logic                          empty;
	logic [CMP_W-1:0]              cap_eff;
	logic [AW-1:0]                 pos_a;
	logic [AW-1:0]                 cnt_a;
	logic [AW-1:0]                 cnt_m1;
	logic [AW-1:0]                 del_k;
	logic [WORD_BITS-1:0]          word_ext;

	logic [cal_pkg::STAT_W-1:0]    acc_status;
	logic [2:0]                    acc_next;
	logic                          acc_inc;
	logic                          acc_dec;

	logic                          mem_we;
	logic [AW-1:0]                 waddr;
	logic [AW-1:0]                 raddr;
	logic [WORD_BITS-1:0]          wdata;

	cal_apb u_apb (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.capacity (capacity)
	);

	// Command decode against the current count and capacity
	assign accept   = start && (state_q == S_IDLE);
	assign cap_eff  = (CMP_W'(capacity) > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : CMP_W'(capacity);
	assign full     = CMP_W'(count_q) >= cap_eff;
	assign valid    = CMP_W'(position) < CMP_W'(count_q);
	assign empty    = (count_q == '0);
	assign pos_a    = AW'(position);
	assign cnt_a    = count_q[AW-1:0];
	assign cnt_m1   = cnt_a - AW'(1);
	assign del_k    = (cmd == cal_pkg::CMD_REMOVE) ? pos_a : '0;
	assign word_ext = WORD_BITS'(word_in);

	// Outcome of the command waiting on the channel
	always_comb begin
		acc_status = cal_pkg::ST_OK;
		acc_next   = S_IDLE;
		acc_inc    = 1'b0;
		acc_dec    = 1'b0;
		case (cmd)
			cal_pkg::CMD_GET: begin
				if (valid) acc_next = S_GET;
				else acc_status = cal_pkg::ST_BAD_INDEX;
			end
			cal_pkg::CMD_SET: begin
				if (!valid) acc_status = cal_pkg::ST_BAD_INDEX;
			end
			cal_pkg::CMD_APPEND: begin
				if (full) acc_status = cal_pkg::ST_FULL;
				else acc_inc = 1'b1;
			end
			cal_pkg::CMD_DROP: begin
				if (empty) acc_status = cal_pkg::ST_EMPTY;
				else acc_dec = 1'b1;
			end
			cal_pkg::CMD_INSERT, cal_pkg::CMD_PUSH: begin
				if (full) begin
					acc_status = cal_pkg::ST_FULL;
				end else if (cmd == cal_pkg::CMD_INSERT && !valid) begin
					acc_status = cal_pkg::ST_BAD_INDEX;
				end else if (empty) begin
					// push front on an empty list: written directly
					acc_inc = 1'b1;
				end else begin
					acc_next = S_SHUP;
				end
			end
			default: begin
				// remove at / pop front
				if (cmd == cal_pkg::CMD_REMOVE && !valid) begin
					acc_status = cal_pkg::ST_BAD_INDEX;
				end else if (empty) begin
					acc_status = cal_pkg::ST_EMPTY;
				end else if (del_k == cnt_m1) begin
					acc_dec = 1'b1;
				end else begin
					acc_next = S_SHDN;
				end
			end
		endcase
	end

	// Store port control
	always_comb begin
		mem_we = 1'b0;
		waddr  = ptr_q + AW'(1);
		wdata  = rdata_q;
		raddr  = ptr_q - AW'(1);
		case (state_q)
			S_IDLE: begin
				case (cmd) inside
					cal_pkg::CMD_INSERT, cal_pkg::CMD_PUSH: raddr = cnt_m1;
					cal_pkg::CMD_REMOVE, cal_pkg::CMD_POP:  raddr = del_k + AW'(1);
					default:                                raddr = pos_a;
				endcase
				wdata = word_ext;
				if (accept) begin
					case (cmd)
						cal_pkg::CMD_SET: begin
							mem_we = valid;
							waddr  = pos_a;
						end
						cal_pkg::CMD_APPEND: begin
							mem_we = !full;
							waddr  = cnt_a;
						end
						cal_pkg::CMD_PUSH: begin
							mem_we = !full && empty;
							waddr  = '0;
						end
						default: mem_we = 1'b0;
					endcase
				end
			end
			S_SHUP: begin
				mem_we = 1'b1;
				waddr  = ptr_q + AW'(1);
				raddr  = ptr_q - AW'(1);
			end
			S_SHDN: begin
				mem_we = 1'b1;
				waddr  = ptr_q - AW'(1);
				raddr  = ptr_q + AW'(1);
			end
			S_FIN: begin
				mem_we = ins_q;
				waddr  = pos_q;
				wdata  = word_q;
			end
			default: mem_we = 1'b0;
		endcase
	end

	// Entry store
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	// Payload registers for a pending insert; push front always lands at entry 0
	always_ff @(posedge clk) begin
		if (accept) begin
			pos_q  <= (cmd == cal_pkg::CMD_PUSH) ? '0 : pos_a;
			word_q <= word_ext;
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			ptr_q    <= '0;
			ins_q    <= 1'b0;
			count_q  <= '0;
			done_q   <= 1'b0;
			rword_q  <= '0;
			status_q <= cal_pkg::ST_OK;
		end else begin
			case (state_q)
				S_IDLE: begin
					done_q <= accept && (acc_next == S_IDLE);
					if (accept) begin
						rword_q  <= '0;
						status_q <= acc_status;
						state_q  <= acc_next;
						ins_q    <= (acc_next == S_SHUP);
						ptr_q    <= (acc_next == S_SHUP) ? cnt_m1 : del_k + AW'(1);
						if (acc_inc) count_q <= count_q + CNT_W'(1);
						else if (acc_dec) count_q <= count_q - CNT_W'(1);
					end
				end
				S_GET: begin
					rword_q  <= cal_pkg::WORD_W'(rdata_q);
					status_q <= cal_pkg::ST_OK;
					done_q   <= 1'b1;
					state_q  <= S_IDLE;
				end
				S_SHUP: begin
					done_q <= 1'b0;
					if (ptr_q == pos_q) state_q <= S_FIN;
					else ptr_q <= ptr_q - AW'(1);
				end
				S_SHDN: begin
					done_q <= 1'b0;
					if (ptr_q == cnt_m1) state_q <= S_FIN;
					else ptr_q <= ptr_q + AW'(1);
				end
				S_FIN: begin
					if (ins_q) count_q <= count_q + CNT_W'(1);
					else count_q <= count_q - CNT_W'(1);
					status_q <= cal_pkg::ST_OK;
					done_q   <= 1'b1;
					state_q  <= S_IDLE;
				end
				default: begin
					done_q  <= 1'b0;
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy        = (state_q != S_IDLE);
	assign done        = done_q;
	assign read_word   = rword_q;
	assign status      = status_q;
	assign entry_count = cal_pkg::CNT_O_W'(count_q);

endmodule

### src/cal_checker.sv
`timescale 1ns / 1ps

module cal_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic                              busy,
	input  logic                              done,
	input  logic signed [cal_pkg::WORD_W-1:0] read_word,
	input  logic [cal_pkg::STAT_W-1:0]        status,
	input  logic [cal_pkg::CNT_O_W-1:0]       entry_count,
	input  logic                              pready
);

	// A result only follows an accepted or running transaction
	a_done_cause: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy || start))
		else $error("done without a transaction in flight");

	// An accepted transaction either finishes at once or holds busy
	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy || done))
		else $error("accepted transaction dropped");

	// Failed commands return zero data
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != cal_pkg::ST_OK) |-> (read_word == '0))
		else $error("nonzero read_word on error");

	// Empty status only on an empty list
	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == cal_pkg::ST_EMPTY) |-> (entry_count == '0))
		else $error("empty status with entries present");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");

endmodule

bind contiguous_array_list_top cal_checker u_cal_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.done        (done),
	.read_word   (read_word),
	.status      (status),
	.entry_count (entry_count),
	.pready      (pready)
);
